// ----- hdl/multichannel_moving_average_zone_defines.svh -----
// assertion macros shared by the filter modules
`ifndef MULTICHANNEL_MOVING_AVERAGE_ZONE_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_ZONE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MMAZ_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmaz assertion failed");

// next-cycle implication, checked outside reset
`define MMAZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmaz assertion failed");

`endif

// ----- hdl/mmaz_pkg.sv -----
package mmaz_pkg;

    // fixed field widths
    localparam int POS_W   = 14;
    localparam int CH_IN_W = 2;
    localparam int BYTE_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // limit register reset values
    localparam logic [POS_W-1:0] ZONE_LOW_RESET  = 14'd4000;
    localparam logic [POS_W-1:0] ZONE_HIGH_RESET = 14'd10000;

    // register map
    typedef enum logic [0:0] {
        REG_ZONE_LOW  = 1'b0,
        REG_ZONE_HIGH = 1'b1
    } t_reg_index;

    // zone codes
    typedef enum logic [1:0] {
        ZONE_NONE = 2'd0,
        ZONE_LOW  = 2'd1,
        ZONE_MID  = 2'd2,
        ZONE_HIGH = 2'd3
    } t_zone;

    // back end sequencer
    typedef enum logic [0:0] {
        BK_READ   = 1'b0,
        BK_UPDATE = 1'b1
    } t_back_state;

    // sample as classified by the front end
    typedef struct packed {
        logic               present;
        logic [CH_IN_W-1:0] channel;
        logic [POS_W-1:0]   pos;
    } t_item;

endpackage

// ----- hdl/mmaz_front.sv -----
module mmaz_front
    import mmaz_pkg::*;
#(
    parameter int SENSORS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CH_IN_W-1:0] i_channel,
    input  logic [BYTE_W-1:0]  i_byte_high,
    input  logic [BYTE_W-1:0]  i_byte_low,
    output logic               o_item_valid,
    output t_item              o_item,
    input  logic               i_item_pop
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [2*BYTE_W-1:0] w_word;
    t_item               w_item;
    logic                w_push;
    logic                w_pop;
    t_item               r_queue [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    // join bytes, drop two low bits, flag channels that exist
    assign w_word         = {i_byte_high, i_byte_low};
    assign w_item.pos     = w_word[2*BYTE_W-1:2];
    assign w_item.channel = i_channel;
    assign w_item.present = (32'(i_channel) < SENSORS);

    // queue handshake
    assign o_ready      = (r_count != QCNT_W'(QDEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign w_pop        = i_item_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_item;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/mmaz_back.sv -----
`include "multichannel_moving_average_zone_defines.svh"

module mmaz_back
    import mmaz_pkg::*;
#(
    parameter int SENSORS = 4,
    parameter int WINDOW  = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    input  t_item                           i_item,
    output logic                            o_item_pop,
    output logic                            o_sum_valid,
    input  logic                            i_sum_ready,
    output logic [CH_IN_W-1:0]              o_sum_channel,
    output logic [POS_W+$clog2(WINDOW)-1:0] o_sum
);

    localparam int CH_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int DEPTH  = SENSORS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = POS_W + $clog2(WINDOW);
    localparam logic [ADDR_W-1:0] WIN_A    = ADDR_W'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(WINDOW - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(WINDOW * ((1 << POS_W) - 1));

    t_back_state       r_state;
    t_back_state       n_state;
    logic              w_adv;
    logic              w_commit;
    logic [CH_W-1:0]   w_ch_idx;
    logic [SLOT_W-1:0] w_slot;
    logic [ADDR_W-1:0] w_addr;
    t_item             r_cur;
    logic [CH_W-1:0]   r_ch_idx;
    logic [SLOT_W-1:0] r_slot;
    logic [ADDR_W-1:0] r_addr;
    logic [POS_W-1:0]  r_store [DEPTH];
    logic [DEPTH-1:0]  r_entry_vld;
    logic [POS_W-1:0]  r_rd_data;
    logic              r_rd_vld;
    logic [SLOT_W-1:0] r_oldest [SENSORS];
    logic [SUM_W-1:0]  r_win_sum [SENSORS];
    logic [POS_W-1:0]  w_old;
    logic [SUM_W-1:0]  w_new_sum;
    logic [SLOT_W-1:0] w_next_slot;
    logic              r_sum_valid;
    logic [CH_IN_W-1:0] r_sum_ch;
    logic [SUM_W-1:0]  r_sum;

    // result register frees up this cycle
    assign w_adv = !r_sum_valid || i_sum_ready;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_READ: begin
                if (i_item_valid) begin
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                if (w_adv) begin
                    n_state = BK_READ;
                end
            end
            default: n_state = BK_READ;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_item_pop = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            BK_READ:   o_item_pop = i_item_valid;
            BK_UPDATE: w_commit   = w_adv;
            default: begin
                o_item_pop = 1'b0;
                w_commit   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_READ;
        end else begin
            r_state <= n_state;
        end
    end

    // store address of the oldest sample of this channel
    assign w_ch_idx = i_item.present ? CH_W'(i_item.channel) : '0;
    assign w_slot   = r_oldest[w_ch_idx];
    assign w_addr   = ADDR_W'(w_ch_idx) * WIN_A + ADDR_W'(w_slot);

    // capture the item being worked on
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_cur    <= i_item;
            r_ch_idx <= w_ch_idx;
            r_slot   <= w_slot;
            r_addr   <= w_addr;
        end
    end

    // sample store, registered read
    always_ff @(posedge i_clk) begin
        if (w_commit && r_cur.present) begin
            r_store[r_addr] <= r_cur.pos;
        end
        if (o_item_pop) begin
            r_rd_data <= r_store[w_addr];
        end
    end

    // written flags, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (w_commit && r_cur.present) begin
                r_entry_vld[r_addr] <= 1'b1;
            end
            if (o_item_pop) begin
                r_rd_vld <= r_entry_vld[w_addr];
            end
        end
    end

    // running sum and ring index update
    assign w_old       = r_rd_vld ? r_rd_data : '0;
    assign w_new_sum   = r_win_sum[r_ch_idx] - SUM_W'(w_old) + SUM_W'(r_cur.pos);
    assign w_next_slot = (r_slot == SLOT_END) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSORS; i++) begin
                r_oldest[i]  <= '0;
                r_win_sum[i] <= '0;
            end
        end else if (w_commit && r_cur.present) begin
            r_oldest[r_ch_idx]  <= w_next_slot;
            r_win_sum[r_ch_idx] <= w_new_sum;
        end
    end

    // sum handed to the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (w_commit) begin
            r_sum_valid <= 1'b1;
        end else if (i_sum_ready) begin
            r_sum_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_sum_ch <= r_cur.channel;
            r_sum    <= r_cur.present ? w_new_sum : '0;
        end
    end

    assign o_sum_valid   = r_sum_valid;
    assign o_sum_channel = r_sum_ch;
    assign o_sum         = r_sum;

    // checks
    `MMAZ_ASSERT_NEXT(a_update_after_pop, i_clk, i_rst_n, o_item_pop, r_state == BK_UPDATE)
    `MMAZ_ASSERT(a_sum_in_range, i_clk, i_rst_n, r_sum_valid, r_sum <= SUM_MAX)

endmodule

// ----- hdl/mmaz_zone.sv -----
`include "multichannel_moving_average_zone_defines.svh"

module mmaz_zone
    import mmaz_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sum_valid,
    output logic                            o_sum_ready,
    input  logic [CH_IN_W-1:0]              i_sum_channel,
    input  logic [POS_W+$clog2(WINDOW)-1:0] i_sum,
    input  logic [POS_W-1:0]                i_zone_low,
    input  logic [POS_W-1:0]                i_zone_high,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [CH_IN_W-1:0]              o_out_channel,
    output logic [POS_W-1:0]                o_average,
    output logic [1:0]                      o_zone
);

    // floor division by a constant: multiply by a rounded-up reciprocal
    localparam int SUM_W   = POS_W + $clog2(WINDOW);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** SHIFT) + WINDOW - 1) / WINDOW);

    logic [PROD_W-1:0]  w_product;
    logic [POS_W-1:0]   w_avg;
    t_zone              w_zone;
    logic               w_take;
    logic               r_valid;
    logic [CH_IN_W-1:0] r_channel;
    logic [POS_W-1:0]   r_average;
    t_zone              r_zone;

    assign w_product = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign w_avg     = w_product[SHIFT +: POS_W];

    // zone select, tests applied in order
    always_comb begin
        priority if (w_avg == '0) begin
            w_zone = ZONE_NONE;
        end else if (w_avg <= i_zone_low) begin
            w_zone = ZONE_LOW;
        end else if (w_avg <= i_zone_high) begin
            w_zone = ZONE_MID;
        end else begin
            w_zone = ZONE_HIGH;
        end
    end

    // output register
    assign o_sum_ready = !r_valid || i_ready;
    assign w_take      = i_sum_valid && o_sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_channel <= i_sum_channel;
            r_average <= w_avg;
            r_zone    <= w_zone;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_channel = r_channel;
    assign o_average     = r_average;
    assign o_zone        = r_zone;

    // checks
    `MMAZ_ASSERT(a_zero_zone_iff_zero, i_clk, i_rst_n, r_valid, (r_average == '0) == (r_zone == ZONE_NONE))

endmodule

// ----- hdl/multichannel_moving_average_zone.sv -----
// path: input queue, back end read and update states, sum register, output register
// the back end takes a new sample only after its read-then-write sequence on the
//   single-port sample store for the previous sample is done
// reset: synchronous, active low; limits load 4000 and 10000, windows, ring
//   indexes and running sums clear (store entries carry written flags)
module multichannel_moving_average_zone
    import mmaz_pkg::*;
#(
    parameter int SENSORS = 4,
    parameter int WINDOW  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CH_IN_W-1:0] i_channel,
    input  logic [BYTE_W-1:0]  i_byte_high,
    input  logic [BYTE_W-1:0]  i_byte_low,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CH_IN_W-1:0] o_out_channel,
    output logic [POS_W-1:0]   o_average,
    output logic [1:0]         o_zone,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int SUM_W = POS_W + $clog2(WINDOW);

    logic             w_wr;
    t_reg_index       w_reg;
    logic [POS_W-1:0] r_zone_low;
    logic [POS_W-1:0] r_zone_high;
    logic             w_item_valid;
    t_item            w_item;
    logic             w_item_pop;
    logic             w_sum_valid;
    logic             w_sum_ready;
    logic [CH_IN_W-1:0] w_sum_channel;
    logic [SUM_W-1:0] w_sum;

    // limit registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_low  <= ZONE_LOW_RESET;
            r_zone_high <= ZONE_HIGH_RESET;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_ZONE_LOW:  r_zone_low  <= pwdata[POS_W-1:0];
                REG_ZONE_HIGH: r_zone_high <= pwdata[POS_W-1:0];
                default: begin
                    r_zone_low  <= r_zone_low;
                    r_zone_high <= r_zone_high;
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg)
            REG_ZONE_LOW:  prdata = APB_DW'(r_zone_low);
            REG_ZONE_HIGH: prdata = APB_DW'(r_zone_high);
            default:       prdata = '0;
        endcase
    end

    // input side and queue
    mmaz_front #(
        .SENSORS (SENSORS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_channel    (i_channel),
        .i_byte_high  (i_byte_high),
        .i_byte_low   (i_byte_low),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    // window store and running sums
    mmaz_back #(
        .SENSORS (SENSORS),
        .WINDOW  (WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_item_pop    (w_item_pop),
        .o_sum_valid   (w_sum_valid),
        .i_sum_ready   (w_sum_ready),
        .o_sum_channel (w_sum_channel),
        .o_sum         (w_sum)
    );

    // average and zone
    mmaz_zone #(
        .WINDOW (WINDOW)
    ) u_zone (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sum_valid   (w_sum_valid),
        .o_sum_ready   (w_sum_ready),
        .i_sum_channel (w_sum_channel),
        .i_sum         (w_sum),
        .i_zone_low    (r_zone_low),
        .i_zone_high   (r_zone_high),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_channel (o_out_channel),
        .o_average     (o_average),
        .o_zone        (o_zone)
    );

endmodule
